>>> hdl/axis_rest_rescale_hysteresis_assert.svh
// Assertion macros shared by the axis rescale block.
// Depends on nothing; every user module provides clk and rst_n.
`ifndef AXIS_REST_RESCALE_HYSTERESIS_ASSERT_SVH
`define AXIS_REST_RESCALE_HYSTERESIS_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define ARRH_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ARRH_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ARRH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/arrh_pkg.sv
// Shared types and constants of the axis rescale and hysteresis block.
// No dependencies.
package arrh_pkg;

    localparam int AXES        = 6;
    localparam int AXIS_FIELDS = 6;
    localparam int MASK_BITS   = 32;
    localparam int VAL_W       = 16;
    localparam int BTN_W       = 32;
    localparam int NUM_W       = 2 * VAL_W - 1;
    localparam int DIV_STEPS   = VAL_W;
    localparam int RBC_W       = 6;
    localparam int AXC_W       = 3;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    localparam int PRESS_LEVEL   = 16384;
    localparam int RELEASE_LEVEL = 11000;
    localparam int POS_FULL      = 32767;
    localparam int NEG_FULL      = 32768;

    localparam logic [2:0] REG_REST_X      = 3'd0;
    localparam logic [2:0] REG_REST_Y      = 3'd1;
    localparam logic [2:0] REG_REST_Z      = 3'd2;
    localparam logic [2:0] REG_REST_R      = 3'd3;
    localparam logic [2:0] REG_REST_U      = 3'd4;
    localparam logic [2:0] REG_REST_V      = 3'd5;
    localparam logic [2:0] REG_REAL_COUNT  = 3'd6;
    localparam logic [2:0] REG_AXIS_COUNT  = 3'd7;

    typedef struct packed {
        logic signed [VAL_W-1:0] raw_x;
        logic signed [VAL_W-1:0] raw_y;
        logic signed [VAL_W-1:0] raw_z;
        logic signed [VAL_W-1:0] raw_r;
        logic signed [VAL_W-1:0] raw_u;
        logic signed [VAL_W-1:0] raw_v;
        logic [BTN_W-1:0]        raw_buttons;
    } poll_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] pos_x;
        logic signed [VAL_W-1:0] pos_y;
        logic signed [VAL_W-1:0] pos_z;
        logic signed [VAL_W-1:0] pos_r;
        logic signed [VAL_W-1:0] pos_u;
        logic signed [VAL_W-1:0] pos_v;
        logic [BTN_W-1:0]        button_mask;
    } report_t;

    typedef struct packed {
        logic start;
        logic present;
        logic release_lane;
    } lane_ctl_t;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [VAL_W-1:0] value;
    } lane_stat_t;

endpackage

>>> hdl/arrh_lane.sv
// One axis lane: deflection from rest, scaling, and a restoring divider.
// Depends on arrh_pkg and the assertion macro header.
`include "axis_rest_rescale_hysteresis_assert.svh"

module arrh_lane
    import arrh_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lane_ctl_t               ctl,
    input  logic signed [VAL_W-1:0] raw,
    input  logic signed [VAL_W-1:0] rest,
    output lane_stat_t              stat
);

    typedef enum logic [1:0] {L_IDLE, L_DIV, L_DONE} state_t;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic signed [VAL_W:0] SPAN_POS = (VAL_W + 1)'(POS_FULL);
    localparam logic signed [VAL_W:0] SPAN_NEG = (VAL_W + 1)'(NEG_FULL);

    state_t                  state_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [VAL_W-1:0]        rem_reg;
    logic [VAL_W-1:0]        div_reg;
    logic [VAL_W-1:0]        q_reg;
    logic                    neg_reg;
    logic signed [VAL_W-1:0] val_reg;

    logic signed [VAL_W:0]   dev;
    logic signed [VAL_W:0]   span;
    logic                    neg;
    logic                    span_ok;
    logic [VAL_W-1:0]        mag;
    logic [NUM_W-1:0]        num;
    logic [VAL_W:0]          partial;
    logic [VAL_W:0]          diff;
    logic                    ge;
    logic [VAL_W-1:0]        rem_step;
    logic [VAL_W-1:0]        q_step;

    always_comb
    begin
        dev     = {raw[VAL_W-1], raw} - {rest[VAL_W-1], rest};
        neg     = dev[VAL_W];
        mag     = neg ? VAL_W'(-dev) : VAL_W'(dev);
        span    = neg ? ({rest[VAL_W-1], rest} + SPAN_NEG)
                      : (SPAN_POS - {rest[VAL_W-1], rest});
        span_ok = !span[VAL_W] && (span != '0);
        num     = neg ? NUM_W'(mag) * NUM_W'(NEG_FULL)
                      : NUM_W'(mag) * NUM_W'(POS_FULL);
    end

    // one quotient bit per cycle; the remainder stays below the divisor
    always_comb
    begin
        partial  = {rem_reg, q_reg[VAL_W-1]};
        diff     = partial - {1'b0, div_reg};
        ge       = partial >= {1'b0, div_reg};
        rem_step = ge ? diff[VAL_W-1:0] : partial[VAL_W-1:0];
        q_step   = {q_reg[VAL_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            div_reg   <= '0;
            q_reg     <= '0;
            neg_reg   <= 1'b0;
            val_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                L_IDLE:
                begin
                    if (ctl.start)
                    begin
                        neg_reg <= neg;
                        div_reg <= span[VAL_W-1:0];
                        rem_reg <= VAL_W'(num[NUM_W-1:VAL_W]);
                        q_reg   <= num[VAL_W-1:0];
                        cnt_reg <= '0;
                        if (ctl.present && span_ok)
                        begin
                            state_reg <= L_DIV;
                        end
                        else
                        begin
                            // absent axis or empty range reads zero
                            val_reg   <= '0;
                            state_reg <= L_DONE;
                        end
                    end
                end
                L_DIV:
                begin
                    rem_reg <= rem_step;
                    q_reg   <= q_step;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                    begin
                        val_reg   <= neg_reg ? VAL_W'(-q_step) : q_step;
                        state_reg <= L_DONE;
                    end
                end
                L_DONE:
                begin
                    if (ctl.release_lane)
                    begin
                        state_reg <= L_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign stat.busy  = (state_reg != L_IDLE);
    assign stat.done  = (state_reg == L_DONE);
    assign stat.value = val_reg;

    `ARRH_ASSERT_IMPL(a_rem_below_div, state_reg == L_DIV, rem_reg < div_reg, "divider remainder not below divisor")

endmodule

>>> hdl/arrh_merge.sv
// Merge stage: real button masking, synthetic axis buttons with hysteresis,
// and the report register. Depends on arrh_pkg and the assertion macro header.
`include "axis_rest_rescale_hysteresis_assert.svh"

module arrh_merge
    import arrh_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  logic signed [VAL_W-1:0] vals [AXES],
    input  logic [BTN_W-1:0]        buttons,
    input  logic [RBC_W-1:0]        real_button_count,
    input  logic                    report_ready,
    output report_t                 report,
    output logic                    report_valid
);

    localparam int POS_W  = $clog2(MASK_BITS + 2 * AXES + 2);
    localparam int PAIR_W = 2 * AXES;
    localparam logic [PAIR_W-1:0] MINUS_BITS = {AXES{2'b01}};
    localparam logic signed [VAL_W:0] PRESS_THR   = (VAL_W + 1)'(PRESS_LEVEL);
    localparam logic signed [VAL_W:0] RELEASE_THR = (VAL_W + 1)'(RELEASE_LEVEL);

    logic [PAIR_W-1:0]       pair_pressed_reg;
    logic [PAIR_W-1:0]       pair_next;
    logic [PAIR_W-1:0]       fit_pairs;
    report_t                 report_reg;
    report_t                 report_next;
    logic                    report_valid_reg;

    logic [POS_W-1:0]        nreal;
    logic [MASK_BITS-1:0]    real_mask;
    logic [63:0]             btn_wide;
    logic [MASK_BITS-1:0]    mask_next;
    logic [63:0]             mask_wide;
    logic [POS_W-1:0]        bit_pos  [AXES];
    logic                    fits     [AXES];
    logic signed [VAL_W:0]   val_ext  [AXES];
    logic signed [VAL_W:0]   minus_thr[AXES];
    logic signed [VAL_W:0]   plus_thr [AXES];
    logic                    minus    [AXES];
    logic                    plus     [AXES];
    logic signed [VAL_W-1:0] pos_fields [AXIS_FIELDS];

    always_comb
    begin
        nreal = (POS_W'(real_button_count) > POS_W'(MASK_BITS)) ? POS_W'(MASK_BITS)
                                                                 : POS_W'(real_button_count);
        for (int b = 0; b < MASK_BITS; b++)
        begin
            real_mask[b] = POS_W'(b) < nreal;
        end
        btn_wide = 64'(buttons);
    end

    always_comb
    begin
        mask_next = btn_wide[MASK_BITS-1:0] & real_mask;
        pair_next = '0;
        fit_pairs = '0;
        for (int a = 0; a < AXES; a++)
        begin
            bit_pos[a]   = nreal + POS_W'(2 * a);
            fits[a]      = POS_W'(bit_pos[a] + 1'b1) < POS_W'(MASK_BITS);
            val_ext[a]   = {vals[a][VAL_W-1], vals[a]};
            // a pressed button releases only at the lower level
            minus_thr[a] = pair_pressed_reg[2 * a] ? -RELEASE_THR : -PRESS_THR;
            plus_thr[a]  = pair_pressed_reg[2 * a + 1] ? RELEASE_THR : PRESS_THR;
            minus[a]     = fits[a] && (val_ext[a] < minus_thr[a]);
            plus[a]      = fits[a] && (val_ext[a] > plus_thr[a]);
            pair_next[2 * a]     = minus[a];
            pair_next[2 * a + 1] = plus[a];
            fit_pairs[2 * a]     = fits[a];
            fit_pairs[2 * a + 1] = fits[a];
            mask_next = mask_next | (MASK_BITS'(minus[a]) << bit_pos[a])
                                  | (MASK_BITS'(plus[a]) << (bit_pos[a] + 1'b1));
        end
        mask_wide = 64'(mask_next);
    end

    for (genvar k = 0; k < AXIS_FIELDS; k++)
    begin : g_fields
        if (k < AXES)
        begin : g_axis
            assign pos_fields[k] = vals[k];
        end
        else
        begin : g_absent
            assign pos_fields[k] = '0;
        end
    end

    always_comb
    begin
        report_next.pos_x       = pos_fields[0];
        report_next.pos_y       = pos_fields[1];
        report_next.pos_z       = pos_fields[2];
        report_next.pos_r       = pos_fields[3];
        report_next.pos_u       = pos_fields[4];
        report_next.pos_v       = pos_fields[5];
        report_next.button_mask = mask_wide[BTN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_pressed_reg <= '0;
            report_valid_reg <= 1'b0;
            report_reg       <= '0;
        end
        else if (fire)
        begin
            pair_pressed_reg <= pair_next;
            report_reg       <= report_next;
            report_valid_reg <= 1'b1;
        end
        else if (report_ready)
        begin
            report_valid_reg <= 1'b0;
        end
    end

    assign report       = report_reg;
    assign report_valid = report_valid_reg;

    `ARRH_ASSERT_NEXT(a_unfit_pairs_clear, fire, (pair_pressed_reg & ~$past(fit_pairs)) == '0, "pair held beyond mask width")
    `ARRH_ASSERT_ALWAYS(a_pair_exclusive, (pair_pressed_reg & (pair_pressed_reg >> 1) & MINUS_BITS) == '0, "minus and plus pressed together")

endmodule

>>> hdl/axis_rest_rescale_hysteresis.sv
// Game pad axis rescale with synthetic hysteresis buttons; uses arrh_pkg, arrh_lane, arrh_merge.
// A poll is taken by the lanes, divided by the 16-step divider where a lane must divide, and
// registered as a report once every lane is done; a new poll is taken only after the last is handed over;
// a finished report waits in the output register while the next poll is taken.
// Reset (rst_n, asynchronous, active low) clears rest points, counts and pressed pairs.
`include "axis_rest_rescale_hysteresis_assert.svh"

module axis_rest_rescale_hysteresis
    import arrh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              poll_valid,
    output logic              poll_ready,
    input  poll_t             poll,
    output logic              report_valid,
    input  logic              report_ready,
    output report_t           report
);

    logic signed [VAL_W-1:0] rest_reg [AXIS_FIELDS];
    logic [RBC_W-1:0]        real_count_reg;
    logic [AXC_W-1:0]        axis_count_reg;
    logic                    busy_reg;
    logic [BTN_W-1:0]        buttons_reg;

    logic                    cfg_wr;
    logic [2:0]              cfg_idx;
    logic                    poll_acc;
    logic                    fire;
    logic signed [VAL_W-1:0] raw_arr  [AXIS_FIELDS];
    lane_ctl_t               lane_ctl [AXES];
    lane_stat_t              lane_stat[AXES];
    logic signed [VAL_W-1:0] lane_vals[AXES];
    logic [AXES-1:0]         lane_done;
    logic [AXES-1:0]         lane_busy;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < AXIS_FIELDS; r++)
            begin
                rest_reg[r] <= '0;
            end
            real_count_reg <= '0;
            axis_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_REAL_COUNT: real_count_reg <= pwdata[RBC_W-1:0];
                REG_AXIS_COUNT: axis_count_reg <= pwdata[AXC_W-1:0];
                default:        rest_reg[cfg_idx] <= pwdata[VAL_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_REAL_COUNT: prdata = DATA_W'(real_count_reg);
            REG_AXIS_COUNT: prdata = DATA_W'(axis_count_reg);
            default:        prdata = DATA_W'(rest_reg[cfg_idx]);
        endcase
    end

    assign raw_arr[0] = poll.raw_x;
    assign raw_arr[1] = poll.raw_y;
    assign raw_arr[2] = poll.raw_z;
    assign raw_arr[3] = poll.raw_r;
    assign raw_arr[4] = poll.raw_u;
    assign raw_arr[5] = poll.raw_v;

    assign poll_ready = !busy_reg;
    assign poll_acc   = poll_valid && poll_ready;
    // hand over once every lane is done and the report register is free
    assign fire = busy_reg && (&lane_done) && (!report_valid || report_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            buttons_reg <= '0;
        end
        else if (poll_acc)
        begin
            busy_reg    <= 1'b1;
            buttons_reg <= poll.raw_buttons;
        end
        else if (fire)
        begin
            busy_reg <= 1'b0;
        end
    end

    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        assign lane_ctl[a].start        = poll_acc;
        assign lane_ctl[a].present      = AXC_W'(a) < axis_count_reg;
        assign lane_ctl[a].release_lane = fire;
        assign lane_vals[a]             = lane_stat[a].value;
        assign lane_done[a]             = lane_stat[a].done;
        assign lane_busy[a]             = lane_stat[a].busy;

        arrh_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (lane_ctl[a]),
            .raw   (raw_arr[a]),
            .rest  (rest_reg[a]),
            .stat  (lane_stat[a])
        );
    end

    arrh_merge u_merge (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (fire),
        .vals              (lane_vals),
        .buttons           (buttons_reg),
        .real_button_count (real_count_reg),
        .report_ready      (report_ready),
        .report            (report),
        .report_valid      (report_valid)
    );

    `ARRH_ASSERT_NEXT(a_lanes_start, poll_acc, &lane_busy, "lane idle after a request was taken")
    `ARRH_ASSERT_IMPL(a_lanes_idle, !busy_reg, lane_busy == '0, "lane busy while block is idle")

endmodule
